// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Cell type, opcodes and character codes shared by the console writer files.
// ----------------------------------------------------------------------------
package tcw_pkg;

   typedef logic [15:0] cell_type;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_PUT_CHAR   = 2'd0;
   localparam opcode_type OP_SET_CURSOR = 2'd1;
   localparam opcode_type OP_CLEAR      = 2'd2;
   localparam opcode_type OP_READ_CELL  = 2'd3;

   localparam logic [7:0] CH_BACKSPACE  = 8'h08;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_RETURN     = 8'h0D;
   localparam logic [7:0] CH_BLANK      = 8'h20;
   localparam logic [7:0] CH_FIRST_TEXT = 8'h20;
   localparam logic [7:0] CH_LAST_TEXT  = 8'h7F;

   localparam logic [7:0] TAB_MASK      = 8'hF8;
   localparam logic [7:0] TAB_STEP      = 8'd8;

   localparam logic [7:0] RESET_ATTR    = 8'h07;

endpackage

// ===== sv/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// Text console screen store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  tcw_pkg::cell_type wr_data,
   input  logic [AW-1:0]     rd_addr,
   output tcw_pkg::cell_type rd_data
);
   import tcw_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// Teletype engine over a COLUMNS x ROWS store of 16-bit character cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_* with start high; the beat is taken at an edge where
//   busy is low. Opcodes: put char, set cursor, clear, read cell.
//   Response: rsp_strobe is high for one cycle with the cursor, its linear
//   address and (read cell only) the cell value. The receiver cannot stall.
//   Config: csr_wr_en/csr_wr_data write the text attribute; write while idle.
// Timing:
//   Put char and set cursor: response in the cycle after accept, busy stays
//   low, so one item per cycle.
//   Read cell: one memory read, then the registered response.
//   Clear: one store write per cycle over every cell, then the response.
//   Put char that scrolls: a read-copy sweep then a blank row, then the response.
//   The single write port of the screen store sets the sweep lengths.
// Reset: a fill pass writes every cell with busy high; the attribute returns
//   to 7 and the cursor to 0,0.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [6:0]  req_target_col,
   input  logic [4:0]  req_target_row,
   output logic        rsp_strobe,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic [10:0] rsp_cursor_linear,
   output logic [15:0] rsp_cell_value,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_LAST  = AW'(CELLS - COLUMNS - 1);
   localparam logic [AW-1:0] BOTTOM_ROW = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);
   localparam logic [7:0]    COL_LIMIT  = 8'(COLUMNS);
   localparam logic [5:0]    ROW_LIMIT  = 6'(ROWS);
   localparam logic [5:0]    ROW_LAST   = 6'(ROWS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_COPY  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   cell_type      fill_data_ff, fill_data_in;
   logic          resp_pend_ff, resp_pend_in;
   logic          copy_wvalid_ff, copy_wvalid_in;
   logic [AW-1:0] copy_waddr_ff, copy_waddr_in;
   logic [6:0]    cur_col_ff, cur_col_in;
   logic [4:0]    cur_row_ff, cur_row_in;
   logic [7:0]    attr_ff, attr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    rsp_col_ff, rsp_col_in;
   logic [4:0]    rsp_row_ff, rsp_row_in;
   logic [10:0]   rsp_lin_ff, rsp_lin_in;
   cell_type      rsp_cell_ff, rsp_cell_in;

   logic          accept;
   logic [7:0]    pc_col;
   logic [5:0]    pc_row;
   logic          pc_we;
   logic [6:0]    pc_wcol;
   logic [7:0]    pc_char;
   logic          pc_scroll;
   logic [12:0]   pc_lin;
   logic [6:0]    rd_col;
   logic [4:0]    rd_row;
   logic [12:0]   rd_lin;
   logic [12:0]   rsp_lin_full;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   cell_type      mem_wdata;
   logic [AW-1:0] mem_raddr;
   cell_type      mem_rdata;

   assign accept = start && (state_ff == ST_IDLE);

   // put char: cursor motion, cell write, wrap and scroll detect
   always_comb begin
      pc_col    = {1'b0, cur_col_ff};
      pc_row    = {1'b0, cur_row_ff};
      pc_we     = 1'b0;
      pc_wcol   = cur_col_ff;
      pc_char   = CH_BLANK;
      pc_scroll = 1'b0;
      case (req_char_code)
         CH_NEWLINE: begin
            pc_col = 8'd0;
            pc_row = pc_row + 6'd1;
         end
         CH_RETURN: begin
            pc_col = 8'd0;
         end
         CH_TAB: begin
            pc_col = (pc_col + TAB_STEP) & TAB_MASK;
         end
         CH_BACKSPACE: begin
            if (cur_col_ff != 7'd0) begin
               pc_col  = pc_col - 8'd1;
               pc_we   = 1'b1;
               pc_wcol = pc_col[6:0];
            end
         end
         default: begin
            if (req_char_code inside {[CH_FIRST_TEXT:CH_LAST_TEXT]}) begin
               pc_we   = 1'b1;
               pc_char = req_char_code;
               pc_col  = pc_col + 8'd1;
            end
         end
      endcase
      if (pc_col >= COL_LIMIT) begin
         pc_col = 8'd0;
         pc_row = pc_row + 6'd1;
      end
      if (pc_row >= ROW_LIMIT) begin
         pc_scroll = 1'b1;
         pc_row    = ROW_LAST;
      end
   end

   assign pc_lin = 13'(cur_row_ff) * 13'(COLUMNS) + 13'(pc_wcol);

   // read cell: out-of-range coordinates fall back to the cursor
   assign rd_col = ({1'b0, req_target_col} < COL_LIMIT) ? req_target_col : cur_col_ff;
   assign rd_row = ({1'b0, req_target_row} < ROW_LIMIT) ? req_target_row : cur_row_ff;
   assign rd_lin = 13'(rd_row) * 13'(COLUMNS) + 13'(rd_col);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      fill_data_in   = fill_data_ff;
      resp_pend_in   = resp_pend_ff;
      copy_wvalid_in = 1'b0;
      copy_waddr_in  = cnt_ff;
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      attr_in        = csr_wr_en ? csr_wr_data : attr_ff;
      rsp_valid_in   = 1'b0;
      rsp_col_in     = cur_col_ff;
      rsp_row_in     = cur_row_ff;
      rsp_cell_in    = '0;
      mem_we         = 1'b0;
      mem_waddr      = pc_lin[AW-1:0];
      mem_wdata      = {attr_ff, pc_char};
      mem_raddr      = rd_lin[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_PUT_CHAR: begin
                     mem_we     = pc_we;
                     cur_col_in = pc_col[6:0];
                     cur_row_in = pc_row[4:0];
                     if (pc_scroll) begin
                        state_in     = ST_COPY;
                        cnt_in       = '0;
                        fill_data_in = {attr_ff, CH_BLANK};
                        resp_pend_in = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_col_in   = pc_col[6:0];
                        rsp_row_in   = pc_row[4:0];
                     end
                  end
                  OP_SET_CURSOR: begin
                     if ({1'b0, req_target_col} < COL_LIMIT) begin
                        cur_col_in = req_target_col;
                     end
                     if ({1'b0, req_target_row} < ROW_LIMIT) begin
                        cur_row_in = req_target_row;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_col_in   = cur_col_in;
                     rsp_row_in   = cur_row_in;
                  end
                  OP_CLEAR: begin
                     cur_col_in   = '0;
                     cur_row_in   = '0;
                     state_in     = ST_FILL;
                     cnt_in       = '0;
                     fill_data_in = {attr_ff, CH_BLANK};
                     resp_pend_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_READ;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_cell_in  = mem_rdata;
            state_in     = ST_IDLE;
         end
         ST_COPY: begin
            mem_raddr      = cnt_ff + ROW_STRIDE;
            mem_we         = copy_wvalid_ff;
            mem_waddr      = copy_waddr_ff;
            mem_wdata      = mem_rdata;
            copy_wvalid_in = 1'b1;
            cnt_in         = cnt_ff + AW'(1);
            if (cnt_ff == COPY_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            mem_we    = copy_wvalid_ff;
            mem_waddr = copy_waddr_ff;
            mem_wdata = mem_rdata;
            cnt_in    = BOTTOM_ROW;
            state_in  = ST_FILL;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = fill_data_ff;
            cnt_in    = cnt_ff + AW'(1);
            if (cnt_ff == LAST_CELL) begin
               state_in     = ST_IDLE;
               rsp_valid_in = resp_pend_ff;
               resp_pend_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_lin_full = 13'(rsp_row_in) * 13'(COLUMNS) + 13'(rsp_col_in);
   assign rsp_lin_in   = rsp_lin_full[10:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_FILL;
         cnt_ff         <= '0;
         fill_data_ff   <= {RESET_ATTR, CH_BLANK};
         resp_pend_ff   <= 1'b0;
         copy_wvalid_ff <= 1'b0;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         attr_ff        <= RESET_ATTR;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         fill_data_ff   <= fill_data_in;
         resp_pend_ff   <= resp_pend_in;
         copy_wvalid_ff <= copy_wvalid_in;
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         attr_ff        <= attr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_waddr_ff <= copy_waddr_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_lin_ff    <= rsp_lin_in;
      rsp_cell_ff   <= rsp_cell_in;
   end

   tcw_screen_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_linear = rsp_lin_ff;
   assign rsp_cell_value    = rsp_cell_ff;

`ifndef NO_ASSERTIONS
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cur_col_ff} < COL_LIMIT) && ({1'b0, cur_row_ff} < ROW_LIMIT))
      else $error("cursor outside the screen");

   a_accept_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted beat neither answered nor in progress");

   a_cell_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(state_ff) != ST_READ)) |-> (rsp_cell_value == 16'd0))
      else $error("cell value on a response that is not a read");

   a_copy_order: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_COPY) && copy_wvalid_ff) |-> (copy_waddr_ff < mem_raddr))
      else $error("scroll copy overtakes its source");

   a_fill_ends_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FILL) && (cnt_ff == LAST_CELL)) |=> (state_ff == ST_IDLE))
      else $error("fill sweep did not return to idle");
`endif

endmodule
